[hw/rtl/hhp_pkg.sv]
// Shared types, constants and the hex digit decoder for the hop path parser.
// No dependencies; used by every module of the block.
package hhp_pkg;

	localparam int OutCapDefault = 64;  // bytes allowed per text
	localparam int MaxHops       = 63;
	localparam int HopCntW       = 7;   // holds MaxHops + 1
	localparam int HashSizeW     = 2;
	localparam int InDataW       = 8;
	localparam int OutDataW      = 16;  // byte(8) + hops(6) + ok(1), padded

	localparam logic [HashSizeW-1:0] HashSizeReset = 2'd1;
	localparam logic [7:0] ChComma = 8'h2c;
	localparam logic [7:0] ChSpace = 8'h20;
	localparam logic [7:0] ChZero  = 8'h30;
	localparam logic [7:0] ChLowA  = 8'h61;
	localparam logic [7:0] ChUpA   = 8'h41;
	localparam logic [7:0] HexTen  = 8'd10;

	// func codes on the input side, kind codes on the output side
	localparam logic FuncChar    = 1'b0;
	localparam logic FuncEnd     = 1'b1;
	localparam logic KindByte    = 1'b0;
	localparam logic KindStatus  = 1'b1;

	// parser phase, one-hot
	typedef enum logic [3:0] {
		PH_SEP  = 4'b0001,  // between tokens
		PH_HIGH = 4'b0010,  // high digit held
		PH_NEXT = 4'b0100,  // inside a token, next byte expected
		PH_DONE = 4'b1000   // token complete, separator or end expected
	} phase_t;

	typedef struct packed {
		logic       func;
		logic [7:0] char_code;
	} item_t;

	typedef struct packed {
		logic       valid;
		logic       kind;
		logic [7:0] byte_value;
		logic [5:0] hop_count;
		logic       path_ok;
	} result_t;

	typedef struct packed {
		logic       bad;
		logic [3:0] value;
	} hex_t;

	function automatic hex_t hex_decode(input logic [7:0] c);
		hex_t h;
		logic [7:0] t;
		h = '{bad: 1'b0, value: 4'd0};
		t = 8'd0;
		if (c inside {[8'h30:8'h39]}) begin
			t = c - ChZero;
		end else if (c inside {[8'h61:8'h66]}) begin
			t = c - ChLowA + HexTen;
		end else if (c inside {[8'h41:8'h46]}) begin
			t = c - ChUpA + HexTen;
		end else begin
			h.bad = 1'b1;
		end
		h.value = t[3:0];
		return h;
	endfunction

	function automatic logic is_sep(input logic [7:0] c);
		return (c == ChComma) || (c == ChSpace);
	endfunction

endpackage

[hw/rtl/hex_hop_path_parser_top.sv]
// Top level of the hop path text parser: input register, parser step, result register.
// Depends on hhp_pkg and hhp_step.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+--------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | tdata: char_code; tuser: func (1 = end)
//  m_      | out | m_tvalid/m_tready  | tdata: byte_value, hop_count, path_ok;
//          |     |                    | tuser: kind (1 = final status)
//  cfg_    | in  | cfg_wen            | cfg_wdata: hash_size
//
// One character per cycle sustained while m_tready stays high. A request is decoded
// against the parser state while it sits in the input register, and its result (if
// any) moves into the output register that drives m_tvalid once that register is free.
// arst_n clears the parser state, both valid flags and sets hash_size to 1.
// A stalled m_ side holds the output register; the input register then holds
// too, and s_tready drops only once both are full.
module hex_hop_path_parser_top
	import hhp_pkg::*;
#(
	parameter int OUT_CAP = OutCapDefault
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [InDataW-1:0]   s_tdata,   // [7:0] char_code
	input  logic                 s_tuser,   // [0] func
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [OutDataW-1:0]  m_tdata,   // [7:0] byte_value, [13:8] hop_count,
	                                        // [14] path_ok, [15] zero
	output logic                 m_tuser,   // [0] kind
	input  logic                 cfg_wen,
	input  logic [HashSizeW-1:0] cfg_wdata  // hash_size
);

	logic [HashSizeW-1:0] hash_q;
	logic                 valid_s1;
	item_t                item_s1;
	logic                 out_valid_q;
	result_t              res;
	result_t              out_q;
	logic                 advance;
	logic                 out_free;

	// hash size register; the user must write it only while the block is idle (not enforced);
	// a size of zero is accepted here and flagged per character by the step logic
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= HashSizeReset;
		end else if (cfg_wen) begin
			hash_q <= cfg_wdata;
		end
	end

	// stage 1 request moves on once the output register can take its result
	assign out_free = !out_valid_q || m_tready;
	assign advance  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.func      <= s_tuser;
			item_s1.char_code <= s_tdata;
		end
	end

	hhp_step #(
		.OUT_CAP (OUT_CAP)
	) u_step (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.item_s1   (item_s1),
		.hash_size (hash_q),
		.res       (res)
	);

	// result register; status results come from end requests, bytes from low digits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res.valid) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.kind;
	assign m_tdata  = {1'b0, out_q.path_ok, out_q.hop_count, out_q.byte_value};

endmodule

[hw/rtl/hhp_step.sv]
// Parser state registers and the per-character next-state and result logic.
// Depends on hhp_pkg.
module hhp_step
	import hhp_pkg::*;
#(
	parameter int OUT_CAP = OutCapDefault
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,     // item in stage 1 is consumed
	input  item_t                item_s1,
	input  logic [HashSizeW-1:0] hash_size,
	output result_t              res
);

	localparam int TotW = $clog2(OUT_CAP + 1);

	phase_t              phase_q, phase_d;
	logic [3:0]          high_q, high_d;
	logic [1:0]          bih_q, bih_d;
	logic [TotW-1:0]     total_q, total_d;
	logic [HopCntW-1:0]  hops_q, hops_d;
	logic                failed_q, failed_d;

	hex_t                hx;
	logic [1:0]          bih_inc;
	logic [HopCntW-1:0]  hops_inc;
	logic                ok;

	always_comb begin
		hx       = hex_decode(item_s1.char_code);
		bih_inc  = bih_q + 2'd1;
		hops_inc = hops_q + HopCntW'(1);
		ok       = !failed_q && (hash_size != '0)
		           && (phase_q == PH_SEP || phase_q == PH_DONE)
		           && (hops_q <= HopCntW'(MaxHops));

		phase_d  = phase_q;
		high_d   = high_q;
		bih_d    = bih_q;
		total_d  = total_q;
		hops_d   = hops_q;
		failed_d = failed_q;
		res      = '0;

		if (item_s1.func == FuncEnd) begin
			res.valid     = 1'b1;
			res.kind      = KindStatus;
			res.path_ok   = ok;
			res.hop_count = ok ? hops_q[5:0] : 6'd0;
			phase_d  = PH_SEP;
			high_d   = 4'd0;
			bih_d    = 2'd0;
			total_d  = '0;
			hops_d   = '0;
			failed_d = 1'b0;
		end else if (failed_q) begin
			// swallow everything until the end marker
		end else if (hash_size == '0) begin
			failed_d = 1'b1;
		end else begin
			case (phase_q)
				PH_SEP: begin
					if (!is_sep(item_s1.char_code)) begin
						if (hx.bad) begin
							failed_d = 1'b1;
						end else begin
							high_d  = hx.value;
							phase_d = PH_HIGH;
						end
					end
				end
				PH_NEXT: begin
					if (hx.bad) begin
						failed_d = 1'b1;
					end else begin
						high_d  = hx.value;
						phase_d = PH_HIGH;
					end
				end
				PH_DONE: begin
					if (is_sep(item_s1.char_code)) begin
						phase_d = PH_SEP;
					end else begin
						failed_d = 1'b1;
					end
				end
				PH_HIGH: begin
					if (hx.bad || total_q >= TotW'(OUT_CAP)) begin
						failed_d = 1'b1;
					end else begin
						res.valid      = 1'b1;
						res.kind       = KindByte;
						res.byte_value = {high_q, hx.value};
						total_d        = total_q + TotW'(1);
						if (bih_inc >= hash_size) begin
							bih_d   = 2'd0;
							phase_d = PH_DONE;
							hops_d  = hops_inc;
							if (hops_inc > HopCntW'(MaxHops)) failed_d = 1'b1;
						end else begin
							bih_d   = bih_inc;
							phase_d = PH_NEXT;
						end
					end
				end
				default: begin
					phase_d  = PH_SEP;
					failed_d = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SEP;
			high_q   <= 4'd0;
			bih_q    <= 2'd0;
			total_q  <= '0;
			hops_q   <= '0;
			failed_q <= 1'b0;
		end else if (advance) begin
			phase_q  <= phase_d;
			high_q   <= high_d;
			bih_q    <= bih_d;
			total_q  <= total_d;
			hops_q   <= hops_d;
			failed_q <= failed_d;
		end
	end

endmodule

[hw/rtl/hhp_chk.sv]
// Port-level checker for the hop path parser, bound to the top level.
// Depends on hhp_pkg and hex_hop_path_parser_top.
module hhp_chk
	import hhp_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                s_tready,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [OutDataW-1:0] m_tdata,
	input logic                m_tuser
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// byte results carry no status bits
	a_byte_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KindByte |-> m_tdata[15:8] == 8'd0)
		else $error("byte result with status bits");

	// an invalid status reports no hops, no status carries a byte
	a_status_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KindStatus |->
			m_tdata[7:0] == 8'd0 && m_tdata[15] == 1'b0
			&& (m_tdata[14] || m_tdata[13:8] == 6'd0))
		else $error("malformed status result");

	// input side only backs up behind a full output register
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled with output free");

endmodule

bind hex_hop_path_parser_top hhp_chk u_hhp_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

[tb/hhp_path_checker.sv]
// Checker for the hop path parser: watches the request, result and register ports,
// predicts each result and compares it with what the block returns.
// Depends on hhp_pkg for the port widths, phase encoding and character codes.
module hhp_path_checker
	import hhp_pkg::*;
#(
	parameter int OUT_CAP = OutCapDefault
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [InDataW-1:0]   s_tdata,
	input  logic                 s_tuser,
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [OutDataW-1:0]  m_tdata,
	input  logic                 m_tuser,
	input  logic                 cfg_wen,
	input  logic [HashSizeW-1:0] cfg_wdata,
	output int                   fail_count,
	output int                   pending_count
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic       kind;
		logic [7:0] value;
		logic [5:0] hops;
		logic       ok;
	} path_result_t;

	path_result_t expected_q[$];

	logic [HashSizeW-1:0] hop_size;
	phase_t               text_phase;
	logic [3:0]           held_nibble;
	logic [1:0]           bytes_in_hop;
	logic [7:0]           bytes_out;
	logic [HopCntW-1:0]   hops_seen;
	logic                 text_failed;
	int                   mismatches = 0;

	// {bad, value}
	function automatic logic [4:0] hex_nibble(input logic [7:0] c);
		logic [7:0] d;
		d = 8'd0;
		if (c >= ChZero && c <= ChZero + 8'd9) begin
			d = c - ChZero;
		end else if (c >= ChLowA && c <= ChLowA + 8'd5) begin
			d = c - ChLowA + 8'd10;
		end else if (c >= ChUpA && c <= ChUpA + 8'd5) begin
			d = c - ChUpA + 8'd10;
		end else begin
			return 5'b10000;
		end
		return {1'b0, d[3:0]};
	endfunction

	task automatic clear_text();
		text_phase   = PH_SEP;
		held_nibble  = 4'd0;
		bytes_in_hop = 2'd0;
		bytes_out    = 8'd0;
		hops_seen    = '0;
		text_failed  = 1'b0;
	endtask

	task automatic predict_request(input item_t req);
		logic [4:0]   nib;
		logic         sep;
		logic         ok;
		path_result_t res;
		nib = hex_nibble(req.char_code);
		sep = (req.char_code == ChComma) || (req.char_code == ChSpace);
		if (req.func == FuncEnd) begin
			ok = !text_failed && hop_size != 0 && hops_seen <= MaxHops
			     && (text_phase == PH_SEP || text_phase == PH_DONE);
			res = '{kind: KindStatus, value: 8'd0, hops: ok ? hops_seen[5:0] : 6'd0, ok: ok};
			expected_q.push_back(res);
			clear_text();
		end else if (!text_failed) begin
			if (hop_size == 0) begin
				text_failed = 1'b1;
			end else begin
				case (text_phase)
					PH_SEP: begin
						if (!sep) begin
							if (nib[4]) text_failed = 1'b1;
							else begin
								held_nibble = nib[3:0];
								text_phase  = PH_HIGH;
							end
						end
					end
					PH_NEXT: begin
						if (nib[4]) text_failed = 1'b1;
						else begin
							held_nibble = nib[3:0];
							text_phase  = PH_HIGH;
						end
					end
					PH_DONE: begin
						if (sep) text_phase = PH_SEP;
						else text_failed = 1'b1;
					end
					default: begin
						// low digit completes a byte, unless bad or over capacity
						if (nib[4] || bytes_out >= OUT_CAP) begin
							text_failed = 1'b1;
						end else begin
							bytes_out = bytes_out + 8'd1;
							res = '{kind: KindByte, value: {held_nibble, nib[3:0]},
							        hops: 6'd0, ok: 1'b0};
							expected_q.push_back(res);
							bytes_in_hop = bytes_in_hop + 2'd1;
							if (bytes_in_hop >= hop_size) begin
								bytes_in_hop = 2'd0;
								text_phase   = PH_DONE;
								hops_seen    = hops_seen + 1'b1;
								if (hops_seen > MaxHops) text_failed = 1'b1;
							end else begin
								text_phase = PH_NEXT;
							end
						end
					end
				endcase
			end
		end
	endtask

	task automatic check_result();
		path_result_t want;
		path_result_t got;
		got = '{kind: m_tuser, value: m_tdata[7:0], hops: m_tdata[13:8], ok: m_tdata[14]};
		if (expected_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%t hhp_path_checker: unexpected result kind %0b tdata %04h",
				         $realtime, m_tuser, m_tdata);
		end else begin
			want = expected_q.pop_front();
			if (got !== want || m_tdata[15] !== 1'b0) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"%t hhp_path_checker: mismatch (exp/got) kind %0b/%0b",
					          " byte %02h/%02h hops %0d/%0d ok %0b/%0b pad 0/%0b"},
					         $realtime, want.kind, got.kind, want.value, got.value,
					         want.hops, got.hops, want.ok, got.ok, m_tdata[15]);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hop_size = HashSizeReset;
			clear_text();
			expected_q.delete();
			pending_count <= 0;
			fail_count    <= mismatches;
		end else begin
			if (cfg_wen) hop_size = cfg_wdata;
			if (m_tvalid && m_tready) check_result();
			if (s_tvalid && s_tready) predict_request('{func: s_tuser, char_code: s_tdata});
			pending_count <= expected_q.size();
			fail_count    <= mismatches;
		end
	end

endmodule

[tb/tb_hex_hop_path_parser_top.sv]
// Testbench top for hex_hop_path_parser_top: clock, reset, request and stall stimulus,
// register writes, watchdog and verdict. Depends on hhp_pkg and hhp_path_checker.
module tb_hex_hop_path_parser_top;
	import hhp_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int OutCap    = 64;
	localparam int IdleLimit = 4000;  // cycles with no request or result moving
	localparam int NumPhases = 7;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [InDataW-1:0]   s_tdata;   // [7:0] char_code
	logic                 s_tuser;   // [0] func
	logic                 m_tvalid;
	logic                 m_tready;
	logic [OutDataW-1:0]  m_tdata;   // [7:0] byte_value, [13:8] hop_count, [14] path_ok
	logic                 m_tuser;   // [0] kind
	logic                 cfg_wen;
	logic [HashSizeW-1:0] cfg_wdata;

	int fail_cnt;
	int pending;

	// Characters of the text being sent
	logic [7:0] path_text[$];

	// Hop size and request budget of each random phase
	logic [HashSizeW-1:0] phase_size[NumPhases] = '{2'd2, 2'd3, 2'd0, 2'd1, 2'd3, 2'd2, 2'd1};
	int                   phase_budget[NumPhases] = '{300, 300, 60, 300, 300, 300, 300};

	// Quiet stretches: when set, requests get no gaps and no new result stall starts
	logic steady = 1'b0;
	int   steady_cnt = 0;
	int   stall_left = 0;
	int   idle_cycles = 0;
	int   items_sent = 0;

	always begin
		#5ns clk = 1'b1;
		#5ns clk = 1'b0;
	end

	hex_hop_path_parser_top #(
		.OUT_CAP(OutCap)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_wen  (cfg_wen),
		.cfg_wdata(cfg_wdata)
	);

	hhp_path_checker #(
		.OUT_CAP(OutCap)
	) i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser),
		.cfg_wen      (cfg_wen),
		.cfg_wdata    (cfg_wdata),
		.fail_count   (fail_cnt),
		.pending_count(pending)
	);

	// Choose a quiet or noisy stretch at random each time the stretch counter wraps.
	always @(posedge clk) begin
		if (steady_cnt == 299) begin
			steady_cnt <= 0;
			steady     <= ($urandom_range(0, 2) == 0);
		end else begin
			steady_cnt <= steady_cnt + 1;
		end
	end

	// Result side back-pressure: mostly ready, short stalls, now and then a long one.
	always @(posedge clk) begin
		int r;
		r = $urandom_range(0, 99);
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			m_tready   <= 1'b0;
		end else if (steady || r < 70) begin
			m_tready <= 1'b1;
		end else if (r < 95) begin
			m_tready   <= 1'b0;
			stall_left <= $urandom_range(0, 2);
		end else begin
			m_tready   <= 1'b0;
			stall_left <= $urandom_range(9, 39);
		end
	end

	// Watchdog: any cycle moving a request or a result restarts the count.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IdleLimit) begin
			$display("tb_hex_hop_path_parser_top: done, errors");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Gap before a request: mostly none, some short, a few long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [7:0] rand_hex_char();
		int v;
		v = $urandom_range(0, 15);
		if (v < 10) return ChZero + 8'(v);
		return ($urandom_range(0, 1) ? ChUpA : ChLowA) + 8'(v - 10);
	endfunction

	function automatic logic [7:0] rand_sep();
		return $urandom_range(0, 1) ? ChComma : ChSpace;
	endfunction

	// One request; returns right after the edge that accepted it.
	task automatic send_item(input logic fn, input logic [7:0] c);
		int gap;
		gap = pick_gap();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= fn;
		s_tdata  <= c;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		items_sent++;
	endtask

	// char_code is don't-care on the end request, so randomize it
	task automatic send_end();
		send_item(FuncEnd, 8'($urandom_range(0, 255)));
	endtask

	task automatic send_string(input string s);
		for (int i = 0; i < s.len(); i++) send_item(FuncChar, s[i]);
	endtask

	// Drain: wait until every expected result has returned and a trailing request
	// with no result has cleared the two-stage pipeline.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_size(input logic [HashSizeW-1:0] sz);
		cfg_wen   <= 1'b1;
		cfg_wdata <= sz;
		@(posedge clk);
		cfg_wen   <= 1'b0;
	endtask

	// Builds a hop list in path_text. Most texts are well formed with random
	// digits, case and separators; some are damaged or pure noise. A long text
	// takes as many whole hops as the hop and byte limits allow, and may go one hop past.
	task automatic build_text(input logic [HashSizeW-1:0] sz, input logic force_long);
		int n;
		int per_hop;
		int full;
		int pos;
		int r;
		path_text.delete();
		per_hop = (sz == 0) ? 1 : sz;
		full = OutCap / per_hop;
		if (full > MaxHops) full = MaxHops;
		r = $urandom_range(0, 99);
		if (force_long) n = full;
		else if (r < 8) n = full + $urandom_range(0, 1);
		else n = $urandom_range(0, 6);
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 2)) path_text.push_back(rand_sep());
		for (int h = 0; h < n; h++) begin
			if (h != 0) begin
				path_text.push_back(rand_sep());
				if ($urandom_range(0, 3) == 0) path_text.push_back(rand_sep());
			end
			repeat (2 * per_hop) path_text.push_back(rand_hex_char());
		end
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 2)) path_text.push_back(rand_sep());
		if (!force_long && $urandom_range(0, 4) == 0) begin
			pos = (path_text.size() == 0) ? 0 : $urandom_range(0, path_text.size() - 1);
			case ($urandom_range(0, 4))
				0: begin
					if (path_text.size() != 0) path_text[pos] = 8'($urandom_range(0, 255));
					else path_text.push_back(8'($urandom_range(0, 255)));
				end
				1: if (path_text.size() != 0) path_text.delete(pos);
				2: path_text.insert(pos, rand_hex_char());
				3: while (path_text.size() > pos) void'(path_text.pop_back());
				default: begin
					// noise: mix of hex, separators and arbitrary codes
					path_text.delete();
					repeat ($urandom_range(1, 8)) begin
						case ($urandom_range(0, 2))
							0: path_text.push_back(rand_hex_char());
							1: path_text.push_back(rand_sep());
							default: path_text.push_back(8'($urandom_range(0, 255)));
						endcase
					end
				end
			endcase
		end
	endtask

	initial begin
		int   start;
		logic first;

		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= FuncChar;
		cfg_wen   <= 1'b0;
		cfg_wdata <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed texts, hop size 1 from reset
		send_end();                                   // empty text: flood path, 0 hops
		send_string("ff,0A b9");                      // both cases, both separators, byte ff
		send_end();
		send_item(FuncChar, 8'h00);                   // bad character where a token starts
		send_end();
		send_string("1");                             // bad low digit, code 0xff
		send_item(FuncChar, 8'hFF);
		send_end();
		send_string("1,");                            // separator splits a byte
		send_end();
		send_string("123");                           // token one digit too long
		send_end();
		send_string("1");                             // half token at end
		send_end();

		// Hop size shrinks mid-token: second byte closes the hop at size 1
		wait_idle();
		write_size(2'd3);
		send_string("11");
		wait_idle();
		write_size(2'd1);
		send_string("22");
		send_end();

		// Random texts across hop sizes, illegal size 0 included. The first
		// text of each legal phase holds as many whole hops as the hop and byte limits allow.
		for (int p = 0; p < NumPhases; p++) begin
			wait_idle();
			write_size(phase_size[p]);
			first = 1'b1;
			start = items_sent;
			while (items_sent - start < phase_budget[p]) begin
				build_text(phase_size[p], first && phase_size[p] != 0);
				first = 1'b0;
				foreach (path_text[i]) send_item(FuncChar, path_text[i]);
				send_end();
			end
		end

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_cnt == 0 && pending == 0) begin
			$display("tb_hex_hop_path_parser_top: done, clean");
		end else begin
			$display("tb_hex_hop_path_parser_top: done, errors");
		end
		$finish;
	end

endmodule
